// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the clocked assertions of the equalizer RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/tbe_pkg.sv =====
// ---------------------------------------------------------------------------
// tbe_pkg
// Formats, codes, microcode and coefficient ROM of the biquad equalizer.
// ---------------------------------------------------------------------------
package tbe_pkg;

	localparam int SAMPLE_BITS   = 24;
	localparam int SIG_BITS      = 31;   // Q4.27 internal signal
	localparam int SIG_FRAC      = 27;
	localparam int STATE_BITS    = 40;
	localparam int COEF_BITS     = 32;   // Q3.29 coefficients
	localparam int COEF_FRAC     = 29;
	localparam int GAIN_BITS     = 16;   // unsigned Q2.14
	localparam int GAIN_FRAC     = 14;
	localparam int PROD_BITS     = COEF_BITS + SIG_BITS;
	localparam int ACC_BITS      = 64;
	localparam int IN_SHIFT      = SIG_FRAC - (SAMPLE_BITS - 1);
	localparam int OUT_SHIFT     = SIG_FRAC + GAIN_FRAC - (SAMPLE_BITS - 1);
	localparam int NUM_STAGES    = 3;
	localparam int STAGE_BITS    = 2;
	localparam int STEP_BITS     = 4;
	localparam int CFG_IDX_BITS  = 1;
	localparam int CFG_DATA_BITS = 16;
	localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd11583;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_EQ_ENABLE   = 1'b0,
		REG_OUTPUT_GAIN = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		CMD_FILTER = 1'b0,
		CMD_CLEAR  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_HOLD
	} top_state_t;

	typedef enum logic [2:0] {
		C_B0,
		C_B1,
		C_B2,
		C_A1,
		C_A2,
		C_GAIN
	} coef_sel_t;

	typedef enum logic {
		OPB_X,
		OPB_Y
	} opb_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_SUB
	} acc_op_t;

	typedef enum logic [2:0] {
		WB_NONE,
		WB_Y,
		WB_Z1,
		WB_Z2,
		WB_OUT
	} wb_sel_t;

	typedef enum logic [1:0] {
		JMP_NONE,
		JMP_STAGE,   // back to target while stages remain
		JMP_END
	} jump_t;

	typedef struct packed {
		logic                 mul_en;
		coef_sel_t            coef_sel;
		opb_sel_t             opb_sel;
		acc_op_t              acc_op;
		wb_sel_t              wb_sel;
		jump_t                jump;
		logic [STEP_BITS-1:0] target;
	} ucode_t;

	typedef struct packed {
		logic                  valid;
		ucode_t                uc;
		logic [STAGE_BITS-1:0] stage;
	} dp_ctrl_t;

	// Program: eight steps per stage, looped three times, then the gain.
	function automatic ucode_t ucode_rom(input logic [STEP_BITS-1:0] step);
		ucode_t w;
		w = '0;
		unique case (step)
			4'd0: begin  // b0*x
				w.mul_en = 1'b1; w.coef_sel = C_B0; w.opb_sel = OPB_X;
			end
			4'd1: begin  // acc = b0*x; b1*x
				w.acc_op = ACC_LOAD;
				w.mul_en = 1'b1; w.coef_sel = C_B1; w.opb_sel = OPB_X;
			end
			4'd2: begin  // y = rnd(acc) + z1; acc = b1*x
				w.wb_sel = WB_Y; w.acc_op = ACC_LOAD;
			end
			4'd3: begin  // a1*y
				w.mul_en = 1'b1; w.coef_sel = C_A1; w.opb_sel = OPB_Y;
			end
			4'd4: begin  // acc -= a1*y; b2*x
				w.acc_op = ACC_SUB;
				w.mul_en = 1'b1; w.coef_sel = C_B2; w.opb_sel = OPB_X;
			end
			4'd5: begin  // z1 = rnd(acc) + z2; acc = b2*x; a2*y
				w.wb_sel = WB_Z1; w.acc_op = ACC_LOAD;
				w.mul_en = 1'b1; w.coef_sel = C_A2; w.opb_sel = OPB_Y;
			end
			4'd6: begin  // acc -= a2*y
				w.acc_op = ACC_SUB;
			end
			4'd7: begin  // z2 = rnd(acc); next stage
				w.wb_sel = WB_Z2; w.jump = JMP_STAGE; w.target = 4'd0;
			end
			4'd8: begin  // y*gain
				w.mul_en = 1'b1; w.coef_sel = C_GAIN; w.opb_sel = OPB_Y;
			end
			4'd9: begin
				w.acc_op = ACC_LOAD;
			end
			4'd10: begin
				w.wb_sel = WB_OUT; w.jump = JMP_END;
			end
			default: begin
				w.jump = JMP_END;
			end
		endcase
		return w;
	endfunction

	// RBJ designs for 48 kHz, Q3.29.
	function automatic logic signed [COEF_BITS-1:0] coef_rom(
		input logic [STAGE_BITS-1:0] stage,
		input coef_sel_t             sel
	);
		logic signed [COEF_BITS-1:0] c;
		c = '0;
		unique case (stage)
			2'd0: begin
				case (sel)
					C_B0:    c = 32'sd532372484;
					C_B1:    c = -32'sd1064744967;
					C_B2:    c = 32'sd532372484;
					C_A1:    c = -32'sd1064708022;
					C_A2:    c = 32'sd527911001;
					default: c = '0;
				endcase
			end
			2'd1: begin
				case (sel)
					C_B0:    c = 32'sd531782542;
					C_B1:    c = -32'sd1045248105;
					C_B2:    c = 32'sd514383229;
					C_A1:    c = -32'sd1045248105;
					C_A2:    c = 32'sd509294859;
					default: c = '0;
				endcase
			end
			2'd2: begin
				case (sel)
					C_B0:    c = 32'sd532962832;
					C_B1:    c = -32'sd1033521151;
					C_B2:    c = 32'sd502775916;
					C_A1:    c = -32'sd1033521151;
					C_A2:    c = 32'sd498867836;
					default: c = '0;
				endcase
			end
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/tbe_if.sv =====
// ---------------------------------------------------------------------------
// tbe_if
// Valid/ready channels for sample words and result words.
// ---------------------------------------------------------------------------
interface tbe_in_if;
	logic                                     valid;
	logic                                     ready;
	logic                                     command;
	logic signed [tbe_pkg::SAMPLE_BITS-1:0]   sample_in;

	modport source(output valid, command, sample_in, input ready);
	modport sink(input valid, command, sample_in, output ready);
endinterface

interface tbe_out_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [tbe_pkg::SAMPLE_BITS-1:0]   sample_out;

	modport source(output valid, sample_out, input ready);
	modport sink(input valid, sample_out, output ready);
endinterface

// ===== rtl/tbe_seq.sv =====
// ---------------------------------------------------------------------------
// tbe_seq
// Step counter, stage counter and microcode ROM of the equalizer.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tbe_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output tbe_pkg::dp_ctrl_t ctrl,
	output logic              done,
	output logic              busy
);
	import tbe_pkg::*;

	logic [STEP_BITS-1:0]  step_q;
	logic [STAGE_BITS-1:0] stage_q;
	logic                  busy_q;
	ucode_t                uc;
	logic                  more_stages;

	assign uc          = ucode_rom(step_q);
	assign more_stages = (stage_q != STAGE_BITS'(NUM_STAGES - 1));
	assign ctrl        = '{valid: busy_q, uc: uc, stage: stage_q};
	assign done        = busy_q && (uc.jump == JMP_END);
	assign busy        = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= '0;
			stage_q <= '0;
			busy_q  <= 1'b0;
		end else if (start) begin
			step_q  <= '0;
			stage_q <= '0;
			busy_q  <= 1'b1;
		end else if (busy_q) begin
			case (uc.jump)
				JMP_END: begin
					busy_q <= 1'b0;
				end
				JMP_STAGE: begin
					if (more_stages) begin
						step_q  <= uc.target;
						stage_q <= STAGE_BITS'(stage_q + 1'b1);
					end else begin
						step_q <= STEP_BITS'(step_q + 1'b1);
					end
				end
				default: begin
					step_q <= STEP_BITS'(step_q + 1'b1);
				end
			endcase
		end
	end

	`ASSERT_IMPLY(a_stage_range, busy_q, stage_q < STAGE_BITS'(NUM_STAGES), "stage out of range")
	`ASSERT_NEXT(a_done_stops, done, !busy_q, "sequencer still busy after done")

endmodule

// ===== rtl/tbe_dp.sv =====
// ---------------------------------------------------------------------------
// tbe_dp
// Shared multiplier, accumulator and delay words of the three biquads.
// ---------------------------------------------------------------------------
module tbe_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  tbe_pkg::dp_ctrl_t                     ctrl,
	input  logic                                  start,
	input  logic signed [tbe_pkg::SAMPLE_BITS-1:0] sample,
	input  logic                                  clear,
	input  logic [tbe_pkg::GAIN_BITS-1:0]         gain,
	output logic signed [tbe_pkg::SAMPLE_BITS-1:0] result
);
	import tbe_pkg::*;

	localparam int RND_BITS = ACC_BITS - COEF_FRAC;
	localparam int SUM_BITS = STATE_BITS + 2;
	localparam int OUT_BITS = ACC_BITS - OUT_SHIFT;

	localparam logic signed [SUM_BITS-1:0] SIG_MAX   = (SUM_BITS'(1) <<< (SIG_BITS - 1)) - 1;
	localparam logic signed [SUM_BITS-1:0] SIG_MIN   = -(SUM_BITS'(1) <<< (SIG_BITS - 1));
	localparam logic signed [SUM_BITS-1:0] STATE_MAX = (SUM_BITS'(1) <<< (STATE_BITS - 1)) - 1;
	localparam logic signed [SUM_BITS-1:0] STATE_MIN = -(SUM_BITS'(1) <<< (STATE_BITS - 1));
	localparam logic signed [OUT_BITS-1:0] SMP_MAX   = (OUT_BITS'(1) <<< (SAMPLE_BITS - 1)) - 1;
	localparam logic signed [OUT_BITS-1:0] SMP_MIN   = -(OUT_BITS'(1) <<< (SAMPLE_BITS - 1));

	function automatic logic signed [SIG_BITS-1:0] sat_sig(input logic signed [SUM_BITS-1:0] v);
		logic signed [SUM_BITS-1:0] r;
		r = v;
		if (v > SIG_MAX) r = SIG_MAX;
		else if (v < SIG_MIN) r = SIG_MIN;
		return SIG_BITS'(r);
	endfunction

	function automatic logic signed [STATE_BITS-1:0] sat_state(
		input logic signed [SUM_BITS-1:0] v
	);
		logic signed [SUM_BITS-1:0] r;
		r = v;
		if (v > STATE_MAX) r = STATE_MAX;
		else if (v < STATE_MIN) r = STATE_MIN;
		return STATE_BITS'(r);
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
		input logic signed [OUT_BITS-1:0] v
	);
		logic signed [OUT_BITS-1:0] r;
		r = v;
		if (v > SMP_MAX) r = SMP_MAX;
		else if (v < SMP_MIN) r = SMP_MIN;
		return SAMPLE_BITS'(r);
	endfunction

	logic signed [SIG_BITS-1:0]   x_q;
	logic signed [SIG_BITS-1:0]   y_q;
	logic signed [PROD_BITS-1:0]  prod_q;
	logic signed [ACC_BITS-1:0]   acc_q;
	logic signed [STATE_BITS-1:0] z1_q [NUM_STAGES];
	logic signed [STATE_BITS-1:0] z2_q [NUM_STAGES];

	logic signed [COEF_BITS-1:0]  opa;
	logic signed [SIG_BITS-1:0]   opb;
	logic signed [PROD_BITS-1:0]  prod_d;
	logic signed [ACC_BITS-1:0]   prod_ext;
	logic signed [ACC_BITS-1:0]   rnd_sum;
	logic signed [RND_BITS-1:0]   rnd_c;
	logic signed [ACC_BITS-1:0]   out_sum;
	logic signed [OUT_BITS-1:0]   out_r;
	logic signed [SUM_BITS-1:0]   y_sum;
	logic signed [SUM_BITS-1:0]   z1_sum;

	// Operand select; the gain is unsigned, so zero-extend it.
	always_comb begin
		if (ctrl.uc.coef_sel == C_GAIN) opa = $signed(COEF_BITS'(gain));
		else opa = coef_rom(ctrl.stage, ctrl.uc.coef_sel);
		opb = (ctrl.uc.opb_sel == OPB_X) ? x_q : y_q;
	end

	assign prod_d   = opa * opb;
	assign prod_ext = ACC_BITS'(prod_q);

	// Round half up, dropping the coefficient fraction bits.
	assign rnd_sum = acc_q + (ACC_BITS'(1) <<< (COEF_FRAC - 1));
	assign rnd_c   = $signed(rnd_sum[ACC_BITS-1:COEF_FRAC]);
	assign y_sum   = SUM_BITS'(rnd_c) + SUM_BITS'(z1_q[ctrl.stage]);
	assign z1_sum  = SUM_BITS'(rnd_c) + SUM_BITS'(z2_q[ctrl.stage]);

	assign out_sum = acc_q + (ACC_BITS'(1) <<< (OUT_SHIFT - 1));
	assign out_r   = $signed(out_sum[ACC_BITS-1:OUT_SHIFT]);
	assign result  = sat_sample(out_r);

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= SIG_BITS'(sample) <<< IN_SHIFT;
		end else if (ctrl.valid && ctrl.uc.wb_sel == WB_Z2) begin
			x_q <= y_q;   // stage output feeds the next stage
		end
		if (ctrl.valid && ctrl.uc.wb_sel == WB_Y) begin
			y_q <= sat_sig(y_sum);
		end
		if (ctrl.valid && ctrl.uc.mul_en) begin
			prod_q <= prod_d;
		end
		if (ctrl.valid) begin
			case (ctrl.uc.acc_op)
				ACC_LOAD: acc_q <= prod_ext;
				ACC_SUB:  acc_q <= acc_q - prod_ext;
				default:  acc_q <= acc_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_STAGES; i++) begin
				z1_q[i] <= '0;
				z2_q[i] <= '0;
			end
		end else if (clear) begin
			for (int i = 0; i < NUM_STAGES; i++) begin
				z1_q[i] <= '0;
				z2_q[i] <= '0;
			end
		end else if (ctrl.valid) begin
			if (ctrl.uc.wb_sel == WB_Z1) z1_q[ctrl.stage] <= sat_state(z1_sum);
			if (ctrl.uc.wb_sel == WB_Z2) z2_q[ctrl.stage] <= STATE_BITS'(rnd_c);
		end
	end

endmodule

// ===== rtl/three_stage_biquad_equalizer.sv =====
// ---------------------------------------------------------------------------
// three_stage_biquad_equalizer
// Three cascaded biquads (90 Hz high-pass, 320 Hz and 500 Hz peaking cuts)
// with output gain, run by a small microcoded sequencer.
// ---------------------------------------------------------------------------
// One sample word enters, runs through the high-pass and the two peaking
// cuts in transposed direct form II, is scaled by output_gain (unsigned
// Q2.14) and leaves saturated to 24 bits. A filtered sample is accepted,
// runs through 27 microcode steps (eight per stage, three for the gain)
// on the single shared 32x31 multiplier that every product of the program
// goes through, and then moves from the result register into the output
// register. A bypassed sample (eq_enable low) goes through the result
// register to the output register; a clear word gives no result. The next
// word is taken once the current one has reached the output register,
// even while that result waits for the sink. Configuration writes take
// effect at once and are meant for idle periods.
`include "assert_macros.svh"

module three_stage_biquad_equalizer (
	input  logic                                  clk,
	input  logic                                  arst_n,
	tbe_in_if.sink                                sample_chan,
	tbe_out_if.source                             result_chan,
	input  logic                                  cfg_wr_en,
	input  logic [tbe_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [tbe_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
	import tbe_pkg::*;

	top_state_t                     state_q, state_d;
	logic                           eq_enable_q;
	logic [GAIN_BITS-1:0]           output_gain_q;
	logic signed [SAMPLE_BITS-1:0]  res_q;
	logic                           out_valid_q;
	logic signed [SAMPLE_BITS-1:0]  out_data_q;

	logic                           take;
	logic                           seq_start;
	logic                           dp_clear;
	logic                           pass_load;
	logic                           out_load;
	logic                           seq_done;
	logic                           seq_busy;
	dp_ctrl_t                       ctrl;
	logic signed [SAMPLE_BITS-1:0]  dp_result;

	assign sample_chan.ready  = (state_q == ST_IDLE);
	assign take               = sample_chan.valid && sample_chan.ready;
	assign result_chan.valid      = out_valid_q;
	assign result_chan.sample_out = out_data_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eq_enable_q   <= 1'b1;
			output_gain_q <= GAIN_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_EQ_ENABLE:   eq_enable_q   <= cfg_data[0];
				REG_OUTPUT_GAIN: output_gain_q <= cfg_data[GAIN_BITS-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Dispatch: clear words zero the delays, bypassed words go straight to
	// the result register, everything else starts the program.
	always_comb begin
		state_d   = state_q;
		seq_start = 1'b0;
		dp_clear  = 1'b0;
		pass_load = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					if (sample_chan.command == CMD_CLEAR) begin
						dp_clear = 1'b1;
					end else if (eq_enable_q) begin
						seq_start = 1'b1;
						state_d   = ST_RUN;
					end else begin
						pass_load = 1'b1;
						state_d   = ST_HOLD;
					end
				end
			end
			ST_RUN: begin
				if (seq_done) state_d = ST_HOLD;
			end
			ST_HOLD: begin
				// advance only when the output register is free
				if (!out_valid_q || result_chan.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Result word waiting for the output register.
	always_ff @(posedge clk) begin
		if (pass_load) res_q <= sample_chan.sample_in;
		else if (seq_done) res_q <= dp_result;
	end

	// Output register: hold until the sink takes the word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result_chan.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) out_data_q <= res_q;
	end

	tbe_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (seq_start),
		.ctrl   (ctrl),
		.done   (seq_done),
		.busy   (seq_busy)
	);

	tbe_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.start  (seq_start),
		.sample (sample_chan.sample_in),
		.clear  (dp_clear),
		.gain   (output_gain_q),
		.result (dp_result)
	);

	`ASSERT_IMPLY(a_done_in_run, seq_done, state_q == ST_RUN, "program ended outside run state")
	`ASSERT_IMPLY(a_run_busy, state_q == ST_RUN, seq_busy, "run state without active program")
	`ASSERT_IMPLY(a_hold_idle_seq, state_q == ST_HOLD, !seq_busy, "program active while holding")

endmodule
